// ===== hw/rtl/cbpd_pkg.sv =====
// Shared types and constants for the covalent bond pair detector.
`timescale 1ns / 1ps

package cbpd_pkg;

	localparam int MAX_ATOMS_DEF = 64;
	localparam int COORD_W       = 20;
	localparam int RAD_W         = 12;
	localparam int TOL_W         = 16;
	localparam int ATOM_IDX_W    = 7;
	localparam int MASK_W        = 64;
	localparam int DIFF_W        = COORD_W + 1;
	localparam int SQ_W          = 2 * COORD_W + 1;
	localparam int DIST_W        = SQ_W + 1;
	localparam int RSUM_W        = RAD_W + 1;
	localparam int PROD_W        = RSUM_W + TOL_W;
	localparam int PSQ_W         = 2 * PROD_W;
	localparam int LIM_SHIFT     = 28;
	localparam int LIM_W         = PSQ_W - LIM_SHIFT;

	localparam logic [TOL_W-1:0] TOL_RESET = 16'd18350;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic [RAD_W-1:0]          cov_rad;
		logic                      last_atom;
	} atom_t;

	typedef struct packed {
		logic [ATOM_IDX_W-1:0] atom_index;
		logic [MASK_W-1:0]     neighbor_mask;
		logic                  overflow;
	} bond_t;

	// Per-beat control that travels with an atom through the row
	typedef struct packed {
		logic                  vld;
		logic                  ovf;
		logic [ATOM_IDX_W-1:0] idx;
	} meta_t;

	typedef struct packed {
		meta_t meta;
		atom_t atom;
	} qry_t;

endpackage

// ===== hw/rtl/cbpd_cell.sv =====
// One comparison cell: holds one stored atom and tests each passing atom against it.
`timescale 1ns / 1ps

module cbpd_cell import cbpd_pkg::*; #(
	parameter int CELL_IDX = 0,
	parameter int NUM_CELLS = MAX_ATOMS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic [TOL_W-1:0]     tol,
	input  qry_t                 qi,
	input  logic [NUM_CELLS-1:0] mi,
	output qry_t                 qo,
	output meta_t                mo_meta,
	output logic [NUM_CELLS-1:0] mo_mask
);

	localparam logic [NUM_CELLS-1:0] OWN_BIT = NUM_CELLS'(1) << CELL_IDX;
	localparam logic [ATOM_IDX_W-1:0] MY_IDX = ATOM_IDX_W'(CELL_IDX);

	// stored atom, valid only while below the frame count
	logic signed [COORD_W-1:0] px_q, py_q, pz_q;
	logic [RAD_W-1:0]          rad_q;

	meta_t                     fwd_meta_q;
	atom_t                     fwd_atom_q;

	meta_t                     meta_s1, meta_s2, meta_s3, mmeta_q;
	logic                      hit_s1, hit_s2, hit_s3;
	logic signed [DIFF_W-1:0]  dx_s1, dy_s1, dz_s1;
	logic [RSUM_W-1:0]         rsum_s1;
	logic [SQ_W-1:0]           sqx_s2, sqy_s2, sqz_s2;
	logic [PROD_W-1:0]         p_s2;
	logic [DIST_W-1:0]         d2_s3;
	logic [LIM_W-1:0]          lim_s3;
	logic [NUM_CELLS-1:0]      mask_q;

	logic signed [DIFF_W-1:0]  dx_c, dy_c, dz_c;
	logic signed [2*DIFF_W-1:0] sqx_c, sqy_c, sqz_c;
	logic [PROD_W-1:0]         p_c;
	logic [PSQ_W-1:0]          psq_c;
	logic                      hit_c, wr_c, bond_c;

	assign dx_c  = DIFF_W'(qi.atom.pos_x) - DIFF_W'(px_q);
	assign dy_c  = DIFF_W'(qi.atom.pos_y) - DIFF_W'(py_q);
	assign dz_c  = DIFF_W'(qi.atom.pos_z) - DIFF_W'(pz_q);
	assign hit_c = qi.meta.vld && !qi.meta.ovf && (qi.meta.idx > MY_IDX);
	assign wr_c  = qi.meta.vld && !qi.meta.ovf && (qi.meta.idx == MY_IDX);

	assign sqx_c = dx_s1 * dx_s1;
	assign sqy_c = dy_s1 * dy_s1;
	assign sqz_c = dz_s1 * dz_s1;
	assign p_c   = PROD_W'(rsum_s1) * PROD_W'(tol);

	assign psq_c  = PSQ_W'(p_s2) * PSQ_W'(p_s2);
	assign bond_c = hit_s3 && (d2_s3 <= DIST_W'(lim_s3));

	// the atom whose slot this is takes it as it passes
	always_ff @(posedge clk) begin
		if (adv && wr_c) begin
			px_q  <= qi.atom.pos_x;
			py_q  <= qi.atom.pos_y;
			pz_q  <= qi.atom.pos_z;
			rad_q <= qi.atom.cov_rad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_meta_q <= '0;
			meta_s1    <= '0;
			meta_s2    <= '0;
			meta_s3    <= '0;
			mmeta_q    <= '0;
		end else if (adv) begin
			fwd_meta_q <= qi.meta;
			meta_s1    <= qi.meta;
			meta_s2    <= meta_s1;
			meta_s3    <= meta_s2;
			mmeta_q    <= meta_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_atom_q <= qi.atom;
			hit_s1     <= hit_c;
			dx_s1      <= dx_c;
			dy_s1      <= dy_c;
			dz_s1      <= dz_c;
			rsum_s1    <= RSUM_W'(qi.atom.cov_rad) + RSUM_W'(rad_q);
			hit_s2     <= hit_s1;
			sqx_s2     <= sqx_c[SQ_W-1:0];
			sqy_s2     <= sqy_c[SQ_W-1:0];
			sqz_s2     <= sqz_c[SQ_W-1:0];
			p_s2       <= p_c;
			hit_s3     <= hit_s2;
			d2_s3      <= DIST_W'(sqx_s2) + DIST_W'(sqy_s2) + DIST_W'(sqz_s2);
			lim_s3     <= psq_c[PSQ_W-1:LIM_SHIFT];
			mask_q     <= bond_c ? (mi | OWN_BIT) : mi;
		end
	end

	assign qo.meta = fwd_meta_q;
	assign qo.atom = fwd_atom_q;
	assign mo_meta = mmeta_q;
	assign mo_mask = mask_q;

endmodule

// ===== hw/rtl/covalent_bond_pair_detector_top.sv =====
// Top level: frame counter, row of comparison cells and result register.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------
//  atom     | atom_valid/atom_stall | atom   (atom_t, one atom)
//  bond     | bond_valid/bond_stall | bond   (bond_t, one result)
//  cfg      | cfg_valid/cfg_ready   | cfg_data (bond tolerance, Q2.14)
//
// An atom enters cell 0 and moves one cell per cycle unless a result is held; each cell
// registers its comparison through stages s1, s2 and s3 and adds its mask bit in mask_q,
// and the result lands in the bond register. One atom and one result per cycle unless held.
// Reset empties the frame and loads the tolerance with 1.12; stored atoms need no clearing.
// A held result freezes the whole row, and atom_stall rises with it.
`timescale 1ns / 1ps

module covalent_bond_pair_detector_top import cbpd_pkg::*; #(
	parameter int MAX_ATOMS = MAX_ATOMS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             atom_valid,
	output logic             atom_stall,
	input  atom_t            atom,
	output logic             bond_valid,
	input  logic             bond_stall,
	output bond_t            bond,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [TOL_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_ATOMS + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ATOMS);

	logic [CNT_W-1:0]     cnt_q;
	logic [TOL_W-1:0]     tol_q;
	logic                 bond_vld_q;
	bond_t                bond_q;
	logic                 adv, take, full;

	qry_t                 qry_c  [MAX_ATOMS+1];
	meta_t                mmeta_c[MAX_ATOMS];
	logic [MAX_ATOMS-1:0] mask_c [MAX_ATOMS+1];

	assign adv        = !(bond_vld_q && bond_stall);
	assign atom_stall = !adv;
	assign take       = atom_valid && adv;
	assign full       = (cnt_q == CNT_FULL);
	assign cfg_ready  = 1'b1;

	assign qry_c[0].meta.vld = atom_valid;
	assign qry_c[0].meta.ovf = full;
	assign qry_c[0].meta.idx = ATOM_IDX_W'(cnt_q);
	assign qry_c[0].atom     = atom;
	assign mask_c[0]         = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (take) begin
			if (atom.last_atom) begin
				cnt_q <= '0;
			end else if (!full) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	for (genvar j = 0; j < MAX_ATOMS; j++) begin : g_cell
		cbpd_cell #(
			.CELL_IDX  (j),
			.NUM_CELLS (MAX_ATOMS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.tol     (tol_q),
			.qi      (qry_c[j]),
			.mi      (mask_c[j]),
			.qo      (qry_c[j+1]),
			.mo_meta (mmeta_c[j]),
			.mo_mask (mask_c[j+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bond_vld_q <= 1'b0;
		end else if (adv) begin
			bond_vld_q <= mmeta_c[MAX_ATOMS-1].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bond_q.atom_index    <= mmeta_c[MAX_ATOMS-1].idx;
			bond_q.neighbor_mask <= MASK_W'(mask_c[MAX_ATOMS]);
			bond_q.overflow      <= mmeta_c[MAX_ATOMS-1].ovf;
		end
	end

	assign bond_valid = bond_vld_q;
	assign bond       = bond_q;

`ifndef SYNTH
	a_ovf_mask: assert property (@(posedge clk) disable iff (!arst_n)
		bond_valid && bond.overflow |-> bond.neighbor_mask == '0)
		else $error("overflow beat carries mask bits");

	a_ovf_idx: assert property (@(posedge clk) disable iff (!arst_n)
		bond_valid && bond.overflow |-> bond.atom_index == ATOM_IDX_W'(MAX_ATOMS))
		else $error("overflow beat without saturated index");

	a_mask_range: assert property (@(posedge clk) disable iff (!arst_n)
		bond_valid && !bond.overflow |->
		(bond.atom_index < ATOM_IDX_W'(MAX_ATOMS)) &&
		((bond.neighbor_mask >> bond.atom_index) == '0))
		else $error("mask bit at or above atom index");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		take && atom.last_atom |=> cnt_q == '0)
		else $error("store not emptied after last atom");

	a_hold_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		bond_valid && bond_stall |=> $stable(cnt_q))
		else $error("atom taken while result held");
`endif

endmodule

// ===== verif/cbpd_bond_checker.sv =====
// Bond checker: tracks the frame store, predicts each result beat and compares it.
`timescale 1ns / 1ps

module cbpd_bond_checker import cbpd_pkg::*; #(
	parameter int MAX_ATOMS = MAX_ATOMS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             atom_valid,
	input  logic             atom_stall,
	input  atom_t            atom,
	input  logic             bond_valid,
	input  logic             bond_stall,
	input  bond_t            bond,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [TOL_W-1:0] cfg_data,
	output int               mismatches,
	output int               outstanding
);

	atom_t            frame_atoms [MAX_ATOMS];
	int               frame_count;
	logic [TOL_W-1:0] tolerance;
	bond_t            expected_bonds [$];
	bond_t            want;

	// Compare the new atom against every atom kept so far in this frame
	function automatic bond_t predict_bond(input atom_t a);
		bond_t       b;
		longint      dx, dy, dz;
		logic [63:0] dist_sq, reach, limit;
		int          j;
		b = '0;
		if (frame_count >= MAX_ATOMS) begin
			b.atom_index = ATOM_IDX_W'(MAX_ATOMS);
			b.overflow   = 1'b1;
		end else begin
			b.atom_index = ATOM_IDX_W'(frame_count);
			for (j = 0; j < frame_count; j++) begin
				dx = longint'($signed(frame_atoms[j].pos_x)) - longint'($signed(a.pos_x));
				dy = longint'($signed(frame_atoms[j].pos_y)) - longint'($signed(a.pos_y));
				dz = longint'($signed(frame_atoms[j].pos_z)) - longint'($signed(a.pos_z));
				dist_sq = 64'(dx * dx + dy * dy + dz * dz);
				reach   = (64'(a.cov_rad) + 64'(frame_atoms[j].cov_rad))
				          * 64'(tolerance);
				limit   = (reach * reach) >> LIM_SHIFT;
				if (dist_sq <= limit)
					b.neighbor_mask[j] = 1'b1;
			end
		end
		return b;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count = 0;
			tolerance   = TOL_RESET;
			expected_bonds.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				tolerance = cfg_data;

			if (bond_valid && !bond_stall) begin
				if (expected_bonds.size() == 0) begin
					$error("bond beat arrived with no atom waiting for it");
					mismatches++;
				end else begin
					want = expected_bonds.pop_front();
					if (bond.atom_index !== want.atom_index) begin
						$error("atom_index: expected %0d, got %0d",
						       want.atom_index, bond.atom_index);
						mismatches++;
					end
					if (bond.neighbor_mask !== want.neighbor_mask) begin
						$error("neighbor_mask: expected %h, got %h",
						       want.neighbor_mask, bond.neighbor_mask);
						mismatches++;
					end
					if (bond.overflow !== want.overflow) begin
						$error("overflow: expected %0b, got %0b",
						       want.overflow, bond.overflow);
						mismatches++;
					end
				end
			end

			if (atom_valid && !atom_stall) begin
				expected_bonds.push_back(predict_bond(atom));
				if (frame_count < MAX_ATOMS) begin
					frame_atoms[frame_count] = atom;
					frame_count++;
				end
				// Empty the store once the frame's last beat is in
				if (atom.last_atom)
					frame_count = 0;
			end

			outstanding = expected_bonds.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
// Testbench top: atom stimulus, tolerance writes, stall patterns and the verdict.
`timescale 1ns / 1ps

module testbench;
	import cbpd_pkg::*;

	localparam int ITEMS        = 1550;
	localparam int PHASES       = 6;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = MAX_ATOMS_DEF + 8;
	localparam int MARGIN       = 500000;
	localparam int COORD_MAX    = (1 << (COORD_W - 1)) - 1;
	localparam int COORD_MIN    = -(1 << (COORD_W - 1));
	localparam int RAD_MAX      = (1 << RAD_W) - 1;

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             atom_valid = 1'b0;
	logic             atom_stall;
	atom_t            atom       = '0;
	logic             bond_valid;
	logic             bond_stall = 1'b0;
	bond_t            bond;
	logic             cfg_valid  = 1'b0;
	logic             cfg_ready;
	logic [TOL_W-1:0] cfg_data   = '0;

	int               mismatches;
	int               outstanding;
	int               quiet_cycles = 0;
	int               idle_pct     = 0;
	int               stall_pct    = 0;
	int               sent         = 0;
	logic [TOL_W-1:0] tol_now      = TOL_RESET;
	atom_t            prev_atom    = '0;

	covalent_bond_pair_detector_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.atom_valid (atom_valid),
		.atom_stall (atom_stall),
		.atom       (atom),
		.bond_valid (bond_valid),
		.bond_stall (bond_stall),
		.bond       (bond),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	cbpd_bond_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.atom_valid  (atom_valid),
		.atom_stall  (atom_stall),
		.atom        (atom),
		.bond_valid  (bond_valid),
		.bond_stall  (bond_stall),
		.bond        (bond),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		bond_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (atom_valid && !atom_stall) || (bond_valid && !bond_stall)
		    || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("covalent_bond_pair_detector_top: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic atom_t make_atom(input int x, input int y, input int z,
	                                    input int r, input bit last);
		atom_t a;
		a.pos_x       = x[COORD_W-1:0];
		a.pos_y       = y[COORD_W-1:0];
		a.pos_z       = z[COORD_W-1:0];
		a.cov_rad     = r[RAD_W-1:0];
		a.last_atom   = last;
		return a;
	endfunction

	// Place an atom along x at the last integer step within the bond limit of the anchor, or one step past it
	function automatic atom_t near_atom(input atom_t anchor, input int r, input bit last);
		longint reach, limit, s;
		int     offset, x;
		reach = longint'(r + int'(anchor.cov_rad)) * longint'(tol_now);
		limit = (reach * reach) >>> LIM_SHIFT;
		s     = $rtoi($sqrt(real'(limit)));
		while (s * s > limit)
			s--;
		while ((s + 1) * (s + 1) <= limit)
			s++;
		offset = int'(s) + int'($urandom_range(1));
		x      = $signed(anchor.pos_x);
		x      = (x > 0) ? x - offset : x + offset;
		return make_atom(x, $signed(anchor.pos_y), $signed(anchor.pos_z), r, last);
	endfunction

	task automatic push_atom(input atom_t a);
		while ($urandom_range(99) < idle_pct) begin
			atom_valid <= 1'b0;
			@(posedge clk);
		end
		atom_valid <= 1'b1;
		atom       <= a;
		do @(negedge clk); while (atom_stall);
		@(posedge clk);
		prev_atom = a;
		sent++;
	endtask

	task automatic drain_bonds();
		atom_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	task automatic write_tolerance(input logic [TOL_W-1:0] value);
		drain_bonds();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		tol_now    = value;
	endtask

	initial begin
		int    phase, target, len, k, pick, cx, cy, cz;
		bit    long_frame, last;
		atom_t a;
		int    tol_plan [PHASES];

		tol_plan = '{65535, 0, 0, 16384, 0, int'(TOL_RESET)};
		tol_plan[2] = $urandom_range(65535);
		tol_plan[4] = $urandom_range(65535);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed frame at the reset tolerance
		push_atom(make_atom(0, 0, 0, 0, 1'b0));
		push_atom(make_atom(0, 0, 0, 0, 1'b0));
		push_atom(make_atom(COORD_MIN, COORD_MIN, COORD_MIN, RAD_MAX, 1'b0));
		push_atom(make_atom(COORD_MAX, COORD_MAX, COORD_MAX, RAD_MAX, 1'b0));
		push_atom(make_atom(COORD_MAX, COORD_MIN, COORD_MAX, 2048, 1'b0));
		push_atom(make_atom(COORD_MIN, COORD_MAX, COORD_MIN, 1, 1'b0));
		push_atom(make_atom(1000, -1000, 500, 200, 1'b0));
		push_atom(near_atom(prev_atom, 300, 1'b0));
		push_atom(make_atom(1000, -1000, 500, 200, 1'b0));
		push_atom(near_atom(prev_atom, RAD_MAX, 1'b0));
		push_atom(make_atom(1000, -1000, 500, RAD_MAX, 1'b1));
		// Single-atom frames: the store must be empty each time
		push_atom(make_atom(7, 7, 7, 100, 1'b1));
		push_atom(make_atom(7, 7, 7, 100, 1'b1));

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase % 4)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 67;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 67;
				end
				default: begin
					idle_pct  = 12;
					stall_pct = 12;
				end
			endcase
			write_tolerance(tol_plan[phase][TOL_W-1:0]);
			target = (phase + 1) * ITEMS / PHASES;

			// Open each phase with a frame that overruns the store
			len        = 68;
			long_frame = 1'b1;
			while (sent < target) begin
				cx = int'($urandom_range(2 * MARGIN)) - MARGIN;
				cy = int'($urandom_range(2 * MARGIN)) - MARGIN;
				cz = int'($urandom_range(2 * MARGIN)) - MARGIN;
				for (k = 0; k < len; k++) begin
					last = (k == len - 1) || (!long_frame && $urandom_range(7) == 0);
					pick = $urandom_range(99);
					if (pick < 50) begin
						a = make_atom(cx + int'($urandom_range(4096)) - 2048,
						              cy + int'($urandom_range(4096)) - 2048,
						              cz + int'($urandom_range(4096)) - 2048,
						              $urandom_range(640, 64), last);
					end else if (pick < 65 && k > 0) begin
						a = near_atom(prev_atom, $urandom_range(700), last);
					end else if (pick < 75 && k > 0) begin
						a             = prev_atom;
						a.cov_rad     = ($urandom_range(3) == 0) ? '0 : RAD_W'($urandom);
						a.last_atom   = last;
					end else begin
						a = make_atom($urandom, $urandom, $urandom,
						              $urandom_range(RAD_MAX), last);
					end
					push_atom(a);
					if (last)
						break;
				end
				long_frame = ($urandom_range(9) == 0);
				len        = long_frame ? $urandom_range(72, 62) : $urandom_range(16, 1);
			end
		end

		drain_bonds();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("covalent_bond_pair_detector_top: match");
		else
			$display("covalent_bond_pair_detector_top: mismatch");
		$finish;
	end

endmodule
